// ===== sv/ccu_pkg.sv =====
`timescale 1ns / 1ps
// ccu_pkg: shared types and fixed constants of the circumcircle unit
// no dependencies

package ccu_pkg;

   localparam int CENTER_W  = 24;
   localparam int RADIUS_W  = 25;
   localparam int QUOT_BITS = 24;   // quotient magnitude bits before saturation
   localparam int ROOT_BITS = 26;   // root bits resolved by the square-root pipe
   localparam int MID_DEPTH = 4;    // queue between front and back
   localparam int OUT_DEPTH = 2;    // result queue

   localparam logic signed [CENTER_W-1:0] CENTER_MAX = 24'sh7FFFFF;
   localparam logic signed [CENTER_W-1:0] CENTER_MIN = 24'sh800000;
   localparam logic [CENTER_W-1:0]        MAG_MAX_POS = 24'h7FFFFF;
   localparam logic [CENTER_W-1:0]        MAG_MAX_NEG = 24'h800000;

   typedef struct packed {
      logic signed [CENTER_W-1:0] center_x;
      logic signed [CENTER_W-1:0] center_y;
      logic [RADIUS_W-1:0]        radius;
      logic                       degenerate;
      logic                       saturated;
   } ccu_result_type;

   typedef struct packed {
      logic push;
      logic full;
   } ccu_link_type;

endpackage

// ===== sv/ccu_fifo.sv =====
`timescale 1ns / 1ps
// ccu_fifo: small flop-based queue used between pipeline sections
// no dependencies

module ccu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== sv/ccu_front.sv =====
`timescale 1ns / 1ps
// ccu_front: takes point triples, forms the determinant and the centre numerators
// depends on ccu_pkg

module ccu_front import ccu_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_push,
   output logic                           in_full,
   input  logic signed [COORD_BITS-1:0]   p1_x,
   input  logic signed [COORD_BITS-1:0]   p1_y,
   input  logic signed [COORD_BITS-1:0]   p2_x,
   input  logic signed [COORD_BITS-1:0]   p2_y,
   input  logic signed [COORD_BITS-1:0]   p3_x,
   input  logic signed [COORD_BITS-1:0]   p3_y,
   output ccu_link_type                   out_link,
   input  logic                           out_full,
   output logic signed [3*COORD_BITS+5:0] num_x,
   output logic signed [3*COORD_BITS+5:0] num_y,
   output logic signed [2*COORD_BITS+3:0] det,
   output logic signed [COORD_BITS-1:0]   ctr_x,
   output logic signed [COORD_BITS-1:0]   ctr_y,
   output logic                           degen
);

   localparam int CB  = COORD_BITS;
   localparam int UW  = CB + 1;
   localparam int PW  = 2 * UW;
   localparam int SQW = 2 * UW + 1;
   localparam int DW  = 2 * UW + 2;
   localparam int NXW = 3 * UW + 2;
   localparam int NW  = 3 * UW + 3;
   localparam int SK  = SQW / 2;
   localparam int DK  = DW / 2;
   localparam int LW  = UW + SK + 1;
   localparam int HW  = UW + SQW - SK;
   localparam int CLW = CB + DK + 1;
   localparam int CHW = CB + DW - DK;
   localparam int NS  = 6;

   logic [NS-1:0] vld_ff, vld_in;
   logic          en;

   // stage 1: offsets from the third point
   logic signed [UW-1:0] s1_ux_ff, s1_uy_ff, s1_vx_ff, s1_vy_ff;
   logic signed [CB-1:0] s1_cx_ff, s1_cy_ff;
   // stage 2: products
   logic signed [PW-1:0] s2_pxx_ff, s2_pyy_ff, s2_qxx_ff, s2_qyy_ff, s2_c1_ff, s2_c2_ff;
   logic signed [UW-1:0] s2_ux_ff, s2_uy_ff, s2_vx_ff, s2_vy_ff;
   logic signed [CB-1:0] s2_cx_ff, s2_cy_ff;
   // stage 3: squared lengths and determinant
   logic signed [SQW-1:0] s3_uu_ff, s3_vv_ff;
   logic signed [DW-1:0]  s3_det_ff;
   logic signed [UW-1:0]  s3_ux_ff, s3_uy_ff, s3_vx_ff, s3_vy_ff;
   logic signed [CB-1:0]  s3_cx_ff, s3_cy_ff;
   // stage 4: split partial products
   logic signed [HW-1:0]  s4_ah_ff, s4_bh_ff, s4_ch_ff, s4_dh_ff;
   logic signed [LW-1:0]  s4_al_ff, s4_bl_ff, s4_cl_ff, s4_dl_ff;
   logic signed [CHW-1:0] s4_xh_ff, s4_yh_ff;
   logic signed [CLW-1:0] s4_xl_ff, s4_yl_ff;
   logic signed [DW-1:0]  s4_det_ff;
   logic                  s4_degen_ff;
   logic signed [CB-1:0]  s4_cx_ff, s4_cy_ff;
   // stage 5: recombined numerators
   logic signed [NXW-1:0] s5_nx_ff, s5_ny_ff;
   logic signed [NW-1:0]  s5_px_ff, s5_py_ff;
   logic signed [DW-1:0]  s5_det_ff;
   logic                  s5_degen_ff;
   logic signed [CB-1:0]  s5_cx_ff, s5_cy_ff;
   // stage 6: absolute numerators
   logic signed [NW-1:0]  s6_numx_ff, s6_numy_ff;
   logic signed [DW-1:0]  s6_det_ff;
   logic                  s6_degen_ff;
   logic signed [CB-1:0]  s6_cx_ff, s6_cy_ff;

   logic signed [SK:0]         uu_lo, vv_lo;
   logic signed [SQW-SK-1:0]   uu_hi, vv_hi;
   logic signed [DK:0]         det_lo;
   logic signed [DW-DK-1:0]    det_hi;

   assign en            = !vld_ff[NS-1] || !out_full;
   assign in_full       = !en;
   assign out_link.push = vld_ff[NS-1] && !out_full;
   assign out_link.full = out_full;
   assign vld_in        = {vld_ff[NS-2:0], in_push};

   assign uu_lo  = $signed({1'b0, s3_uu_ff[SK-1:0]});
   assign vv_lo  = $signed({1'b0, s3_vv_ff[SK-1:0]});
   assign uu_hi  = $signed(s3_uu_ff[SQW-1:SK]);
   assign vv_hi  = $signed(s3_vv_ff[SQW-1:SK]);
   assign det_lo = $signed({1'b0, s3_det_ff[DK-1:0]});
   assign det_hi = $signed(s3_det_ff[DW-1:DK]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ux_ff <= UW'(p1_x) - UW'(p3_x);
         s1_uy_ff <= UW'(p1_y) - UW'(p3_y);
         s1_vx_ff <= UW'(p2_x) - UW'(p3_x);
         s1_vy_ff <= UW'(p2_y) - UW'(p3_y);
         s1_cx_ff <= p3_x;
         s1_cy_ff <= p3_y;

         s2_pxx_ff <= PW'(s1_ux_ff) * PW'(s1_ux_ff);
         s2_pyy_ff <= PW'(s1_uy_ff) * PW'(s1_uy_ff);
         s2_qxx_ff <= PW'(s1_vx_ff) * PW'(s1_vx_ff);
         s2_qyy_ff <= PW'(s1_vy_ff) * PW'(s1_vy_ff);
         s2_c1_ff  <= PW'(s1_ux_ff) * PW'(s1_vy_ff);
         s2_c2_ff  <= PW'(s1_uy_ff) * PW'(s1_vx_ff);
         s2_ux_ff  <= s1_ux_ff;
         s2_uy_ff  <= s1_uy_ff;
         s2_vx_ff  <= s1_vx_ff;
         s2_vy_ff  <= s1_vy_ff;
         s2_cx_ff  <= s1_cx_ff;
         s2_cy_ff  <= s1_cy_ff;

         s3_uu_ff  <= SQW'(s2_pxx_ff) + SQW'(s2_pyy_ff);
         s3_vv_ff  <= SQW'(s2_qxx_ff) + SQW'(s2_qyy_ff);
         s3_det_ff <= (DW'(s2_c1_ff) - DW'(s2_c2_ff)) <<< 1;
         s3_ux_ff  <= s2_ux_ff;
         s3_uy_ff  <= s2_uy_ff;
         s3_vx_ff  <= s2_vx_ff;
         s3_vy_ff  <= s2_vy_ff;
         s3_cx_ff  <= s2_cx_ff;
         s3_cy_ff  <= s2_cy_ff;

         // nx = vy*uu - uy*vv, ny = ux*vv - vx*uu, each wide factor in two halves
         s4_ah_ff    <= HW'(s3_vy_ff) * HW'(uu_hi);
         s4_al_ff    <= LW'(s3_vy_ff) * LW'(uu_lo);
         s4_bh_ff    <= HW'(s3_uy_ff) * HW'(vv_hi);
         s4_bl_ff    <= LW'(s3_uy_ff) * LW'(vv_lo);
         s4_ch_ff    <= HW'(s3_ux_ff) * HW'(vv_hi);
         s4_cl_ff    <= LW'(s3_ux_ff) * LW'(vv_lo);
         s4_dh_ff    <= HW'(s3_vx_ff) * HW'(uu_hi);
         s4_dl_ff    <= LW'(s3_vx_ff) * LW'(uu_lo);
         s4_xh_ff    <= CHW'(s3_cx_ff) * CHW'(det_hi);
         s4_xl_ff    <= CLW'(s3_cx_ff) * CLW'(det_lo);
         s4_yh_ff    <= CHW'(s3_cy_ff) * CHW'(det_hi);
         s4_yl_ff    <= CLW'(s3_cy_ff) * CLW'(det_lo);
         s4_det_ff   <= s3_det_ff;
         s4_degen_ff <= (s3_det_ff == '0);
         s4_cx_ff    <= s3_cx_ff;
         s4_cy_ff    <= s3_cy_ff;

         s5_nx_ff    <= ((NXW'(s4_ah_ff) <<< SK) + NXW'(s4_al_ff))
                      - ((NXW'(s4_bh_ff) <<< SK) + NXW'(s4_bl_ff));
         s5_ny_ff    <= ((NXW'(s4_ch_ff) <<< SK) + NXW'(s4_cl_ff))
                      - ((NXW'(s4_dh_ff) <<< SK) + NXW'(s4_dl_ff));
         s5_px_ff    <= (NW'(s4_xh_ff) <<< DK) + NW'(s4_xl_ff);
         s5_py_ff    <= (NW'(s4_yh_ff) <<< DK) + NW'(s4_yl_ff);
         s5_det_ff   <= s4_det_ff;
         s5_degen_ff <= s4_degen_ff;
         s5_cx_ff    <= s4_cx_ff;
         s5_cy_ff    <= s4_cy_ff;

         s6_numx_ff  <= s5_px_ff + NW'(s5_nx_ff);
         s6_numy_ff  <= s5_py_ff + NW'(s5_ny_ff);
         s6_det_ff   <= s5_det_ff;
         s6_degen_ff <= s5_degen_ff;
         s6_cx_ff    <= s5_cx_ff;
         s6_cy_ff    <= s5_cy_ff;
      end
   end

   assign num_x = s6_numx_ff;
   assign num_y = s6_numy_ff;
   assign det   = s6_det_ff;
   assign ctr_x = s6_cx_ff;
   assign ctr_y = s6_cy_ff;
   assign degen = s6_degen_ff;

endmodule

// ===== sv/ccu_back.sv =====
`timescale 1ns / 1ps
// ccu_back: divides out the centre, clamps it and takes the radius root
// depends on ccu_pkg

module ccu_back import ccu_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_pop,
   input  logic signed [3*COORD_BITS+5:0] num_x,
   input  logic signed [3*COORD_BITS+5:0] num_y,
   input  logic signed [2*COORD_BITS+3:0] det,
   input  logic signed [COORD_BITS-1:0]   ctr_x,
   input  logic signed [COORD_BITS-1:0]   ctr_y,
   input  logic                           degen,
   output ccu_link_type                   out_link,
   input  logic                           out_full,
   output ccu_result_type                 result
);

   localparam int CB  = COORD_BITS;
   localparam int UW  = CB + 1;
   localparam int DW  = 2 * UW + 2;
   localparam int NW  = 3 * UW + 3;
   localparam int QB  = QUOT_BITS;
   localparam int MW  = (NW > DW + QB) ? NW : DW + QB;
   localparam int RB  = ROOT_BITS;
   localparam int SRW = 2 * RB + 2;
   localparam int DXW = CENTER_W + 1;
   localparam int SQW = 2 * DXW;
   localparam int NS  = QB + 6 + RB;

   typedef struct packed {
      logic [DW-1:0]        rem_x;
      logic [DW-1:0]        rem_y;
      logic [QB-1:0]        low_x;
      logic [QB-1:0]        low_y;
      logic [QB-1:0]        q_x;
      logic [QB-1:0]        q_y;
      logic [DW-1:0]        dm;
      logic                 ov_x;
      logic                 ov_y;
      logic                 sg_x;
      logic                 sg_y;
      logic signed [CB-1:0] cx;
      logic signed [CB-1:0] cy;
      logic                 degen;
   } div_type;

   typedef struct packed {
      logic [SRW-1:0]             rem;
      logic [RB-1:0]              root;
      logic signed [CENTER_W-1:0] qx;
      logic signed [CENTER_W-1:0] qy;
      logic                       sat;
      logic                       degen;
   } root_type;

   function automatic div_type div_step(input div_type s, input int bi);
      div_type     n;
      logic [DW:0] tx, ty;
      n  = s;
      tx = {s.rem_x, s.low_x[bi]};
      ty = {s.rem_y, s.low_y[bi]};
      if (tx >= {1'b0, s.dm}) begin
         n.rem_x   = DW'(tx - {1'b0, s.dm});
         n.q_x[bi] = 1'b1;
      end else begin
         n.rem_x = DW'(tx);
      end
      if (ty >= {1'b0, s.dm}) begin
         n.rem_y   = DW'(ty - {1'b0, s.dm});
         n.q_y[bi] = 1'b1;
      end else begin
         n.rem_y = DW'(ty);
      end
      return n;
   endfunction

   function automatic root_type root_step(input root_type s, input int bi);
      root_type       n;
      logic [SRW-1:0] test;
      n    = s;
      test = (SRW'(s.root) << (bi + 1)) + (SRW'(1) << (2 * bi));
      if (s.rem >= test) begin
         n.rem      = s.rem - test;
         n.root[bi] = 1'b1;
      end
      return n;
   endfunction

   function automatic logic clamp_hit(input logic sg, input logic ov,
                                      input logic [QB-1:0] mag);
      return ov || (sg ? (mag > MAG_MAX_NEG) : (mag > MAG_MAX_POS));
   endfunction

   function automatic logic signed [CENTER_W-1:0] clamp_val(input logic sg, input logic ov,
                                                            input logic [QB-1:0] mag);
      logic signed [CENTER_W-1:0] v;
      if (clamp_hit(sg, ov, mag)) begin
         v = sg ? CENTER_MIN : CENTER_MAX;
      end else begin
         v = sg ? -$signed(mag) : $signed(mag);
      end
      return v;
   endfunction

   logic [NS-1:0] vld_ff, vld_in;
   logic          en;

   // magnitudes and quotient signs
   logic [NW-1:0]        b0_nmx_ff, b0_nmy_ff;
   logic [DW-1:0]        b0_dm_ff;
   logic                 b0_sx_ff, b0_sy_ff, b0_degen_ff;
   logic signed [CB-1:0] b0_cx_ff, b0_cy_ff;

   div_type div_ff [QB+1];
   div_type div_nx [QB];
   div_type div_in;

   // clamped centre
   logic signed [CENTER_W-1:0] c_qx_ff, c_qy_ff;
   logic                       c_sat_ff, c_degen_ff;
   logic signed [CB-1:0]       c_cx_ff, c_cy_ff;
   // offsets to the third point
   logic signed [DXW-1:0]      d_dx_ff, d_dy_ff;
   logic signed [CENTER_W-1:0] d_qx_ff, d_qy_ff;
   logic                       d_sat_ff, d_degen_ff;
   // squares
   logic [SQW-1:0]             e_sx_ff, e_sy_ff;
   logic signed [CENTER_W-1:0] e_qx_ff, e_qy_ff;
   logic                       e_sat_ff, e_degen_ff;
   // squared distance
   logic [SRW-1:0]             f_d2_ff;
   logic signed [CENTER_W-1:0] f_qx_ff, f_qy_ff;
   logic                       f_sat_ff, f_degen_ff;

   root_type rt_ff [RB];
   root_type rt_nx [RB];
   root_type rt_in;

   assign en            = !vld_ff[NS-1] || !out_full;
   assign in_pop        = en && in_valid;
   assign out_link.push = vld_ff[NS-1] && !out_full;
   assign out_link.full = out_full;
   assign vld_in        = {vld_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      div_in       = '0;
      div_in.rem_x = DW'(b0_nmx_ff >> QB);
      div_in.rem_y = DW'(b0_nmy_ff >> QB);
      div_in.low_x = b0_nmx_ff[QB-1:0];
      div_in.low_y = b0_nmy_ff[QB-1:0];
      div_in.dm    = b0_dm_ff;
      // quotient would not fit the magnitude bits: clamp outright
      div_in.ov_x  = MW'(b0_nmx_ff) >= (MW'(b0_dm_ff) << QB);
      div_in.ov_y  = MW'(b0_nmy_ff) >= (MW'(b0_dm_ff) << QB);
      div_in.sg_x  = b0_sx_ff;
      div_in.sg_y  = b0_sy_ff;
      div_in.cx    = b0_cx_ff;
      div_in.cy    = b0_cy_ff;
      div_in.degen = b0_degen_ff;
   end

   for (genvar k = 0; k < QB; k++) begin : g_div
      assign div_nx[k] = div_step(div_ff[k], QB - 1 - k);
   end

   always_comb begin
      rt_in       = '0;
      rt_in.rem   = f_d2_ff;
      rt_in.qx    = f_qx_ff;
      rt_in.qy    = f_qy_ff;
      rt_in.sat   = f_sat_ff;
      rt_in.degen = f_degen_ff;
   end

   assign rt_nx[0] = root_step(rt_in, RB - 1);
   for (genvar k = 1; k < RB; k++) begin : g_root
      assign rt_nx[k] = root_step(rt_ff[k-1], RB - 1 - k);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b0_nmx_ff   <= num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
         b0_nmy_ff   <= num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
         b0_dm_ff    <= det[DW-1] ? DW'(-det) : DW'(det);
         b0_sx_ff    <= num_x[NW-1] ^ det[DW-1];
         b0_sy_ff    <= num_y[NW-1] ^ det[DW-1];
         b0_cx_ff    <= ctr_x;
         b0_cy_ff    <= ctr_y;
         b0_degen_ff <= degen;

         div_ff[0] <= div_in;
         for (int k = 0; k < QB; k++) begin
            div_ff[k+1] <= div_nx[k];
         end

         c_qx_ff    <= clamp_val(div_ff[QB].sg_x, div_ff[QB].ov_x, div_ff[QB].q_x);
         c_qy_ff    <= clamp_val(div_ff[QB].sg_y, div_ff[QB].ov_y, div_ff[QB].q_y);
         c_sat_ff   <= clamp_hit(div_ff[QB].sg_x, div_ff[QB].ov_x, div_ff[QB].q_x)
                    || clamp_hit(div_ff[QB].sg_y, div_ff[QB].ov_y, div_ff[QB].q_y);
         c_cx_ff    <= div_ff[QB].cx;
         c_cy_ff    <= div_ff[QB].cy;
         c_degen_ff <= div_ff[QB].degen;

         d_dx_ff    <= DXW'(c_qx_ff) - DXW'(c_cx_ff);
         d_dy_ff    <= DXW'(c_qy_ff) - DXW'(c_cy_ff);
         d_qx_ff    <= c_qx_ff;
         d_qy_ff    <= c_qy_ff;
         d_sat_ff   <= c_sat_ff;
         d_degen_ff <= c_degen_ff;

         e_sx_ff    <= SQW'(SQW'(d_dx_ff) * SQW'(d_dx_ff));
         e_sy_ff    <= SQW'(SQW'(d_dy_ff) * SQW'(d_dy_ff));
         e_qx_ff    <= d_qx_ff;
         e_qy_ff    <= d_qy_ff;
         e_sat_ff   <= d_sat_ff;
         e_degen_ff <= d_degen_ff;

         f_d2_ff    <= SRW'(e_sx_ff) + SRW'(e_sy_ff);
         f_qx_ff    <= e_qx_ff;
         f_qy_ff    <= e_qy_ff;
         f_sat_ff   <= e_sat_ff;
         f_degen_ff <= e_degen_ff;

         for (int k = 0; k < RB; k++) begin
            rt_ff[k] <= rt_nx[k];
         end
      end
   end

   always_comb begin
      result = '0;
      if (rt_ff[RB-1].degen) begin
         result.degenerate = 1'b1;
      end else begin
         result.center_x  = rt_ff[RB-1].qx;
         result.center_y  = rt_ff[RB-1].qy;
         result.radius    = rt_ff[RB-1].root[RADIUS_W-1:0];
         result.saturated = rt_ff[RB-1].sat;
      end
   end

endmodule

// ===== sv/three_point_circumcircle_unit.sv =====
`timescale 1ns / 1ps
// three_point_circumcircle_unit: circle through three points, top level
// depends on ccu_pkg, ccu_fifo, ccu_front, ccu_back
//
//   channel | ports                         | direction | transfer when
//   --------+-------------------------------+-----------+---------------------
//   request | req_p{1,2,3}_{x,y}            | in        | req_push && !req_full
//   result  | rsp_center_{x,y}, rsp_radius, | out       | rsp_pop && !rsp_empty
//           | rsp_degenerate, rsp_saturated |           |
//
// one triple is taken every cycle and one result leaves every cycle in steady flow,
// while results are popped; the path runs through 6 front stages, one slot of the mid
// queue, QUOT_BITS + 6 + ROOT_BITS back stages and one slot of the result queue:
// 64 stages at the defaults, most of them in the bit-per-stage divider and
// square-root pipes
// synchronous reset empties both queues and clears every stage valid bit; no sweep
// a held result stalls the back section, whose queue then fills and stalls the front

module three_point_circumcircle_unit import ccu_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [COORD_BITS-1:0] req_p1_x,
   input  logic signed [COORD_BITS-1:0] req_p1_y,
   input  logic signed [COORD_BITS-1:0] req_p2_x,
   input  logic signed [COORD_BITS-1:0] req_p2_y,
   input  logic signed [COORD_BITS-1:0] req_p3_x,
   input  logic signed [COORD_BITS-1:0] req_p3_y,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [CENTER_W-1:0]   rsp_center_x,
   output logic signed [CENTER_W-1:0]   rsp_center_y,
   output logic [RADIUS_W-1:0]          rsp_radius,
   output logic                         rsp_degenerate,
   output logic                         rsp_saturated
);

   localparam int CB  = COORD_BITS;
   localparam int NW  = 3 * CB + 6;
   localparam int DW  = 2 * CB + 4;
   localparam int MQW = 2 * NW + DW + 2 * CB + 1;
   localparam int RW  = $bits(ccu_result_type);
   // items the block can hold: front stages, both queues, back stages
   localparam int CAP = 6 + MID_DEPTH + QUOT_BITS + 6 + ROOT_BITS + OUT_DEPTH;
   localparam int IFW = $clog2(CAP + 1);

   // front to mid queue
   ccu_link_type               fr_link;
   logic signed [NW-1:0]       fr_num_x, fr_num_y;
   logic signed [DW-1:0]       fr_det;
   logic signed [CB-1:0]       fr_cx, fr_cy;
   logic                       fr_degen;
   logic                       mq_full;

   // mid queue to back
   logic [MQW-1:0]             mq_rd;
   logic                       mq_empty, mq_pop;
   logic signed [NW-1:0]       bk_num_x, bk_num_y;
   logic signed [DW-1:0]       bk_det;
   logic signed [CB-1:0]       bk_cx, bk_cy;
   logic                       bk_degen;

   // back to result queue
   ccu_link_type               bk_link;
   ccu_result_type             bk_result, rq_result;
   logic [RW-1:0]              rq_rd;
   logic                       rq_full;

   // occupancy tracking for the checks
   logic [IFW-1:0]             inflight_ff, inflight_in;
   logic                       req_xfer, rsp_xfer;

   ccu_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_push  (req_push),
      .in_full  (req_full),
      .p1_x     (req_p1_x),
      .p1_y     (req_p1_y),
      .p2_x     (req_p2_x),
      .p2_y     (req_p2_y),
      .p3_x     (req_p3_x),
      .p3_y     (req_p3_y),
      .out_link (fr_link),
      .out_full (mq_full),
      .num_x    (fr_num_x),
      .num_y    (fr_num_y),
      .det      (fr_det),
      .ctr_x    (fr_cx),
      .ctr_y    (fr_cy),
      .degen    (fr_degen)
   );

   // short queue that lets front and back stall independently
   ccu_fifo #(.WIDTH(MQW), .DEPTH(MID_DEPTH)) u_mid_q (
      .clock   (clock),
      .reset   (reset),
      .push    (fr_link.push),
      .wr_data ({fr_num_x, fr_num_y, fr_det, fr_cx, fr_cy, fr_degen}),
      .full    (mq_full),
      .pop     (mq_pop),
      .rd_data (mq_rd),
      .empty   (mq_empty)
   );

   assign {bk_num_x, bk_num_y, bk_det, bk_cx, bk_cy, bk_degen} = mq_rd;

   ccu_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (!mq_empty),
      .in_pop   (mq_pop),
      .num_x    (bk_num_x),
      .num_y    (bk_num_y),
      .det      (bk_det),
      .ctr_x    (bk_cx),
      .ctr_y    (bk_cy),
      .degen    (bk_degen),
      .out_link (bk_link),
      .out_full (rq_full),
      .result   (bk_result)
   );

   // result queue: a finished result waits here while the pipe keeps going
   ccu_fifo #(.WIDTH(RW), .DEPTH(OUT_DEPTH)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (bk_link.push),
      .wr_data (bk_result),
      .full    (rq_full),
      .pop     (rsp_pop),
      .rd_data (rq_rd),
      .empty   (rsp_empty)
   );

   assign rq_result      = rq_rd;
   assign rsp_center_x   = rq_result.center_x;
   assign rsp_center_y   = rq_result.center_y;
   assign rsp_radius     = rq_result.radius;
   assign rsp_degenerate = rq_result.degenerate;
   assign rsp_saturated  = rq_result.saturated;

   assign req_xfer = req_push && !req_full;
   assign rsp_xfer = rsp_pop && !rsp_empty;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_xfer && !rsp_xfer) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

`ifndef SYNTHESIS
   // collinear points give a flag and nothing else
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_degenerate) |->
         (rsp_center_x == '0 && rsp_center_y == '0 && rsp_radius == '0 && !rsp_saturated))
      else $error("degenerate result carries non-zero fields");

   // a clamped centre sits on a range bound
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_saturated) |->
         (rsp_center_x == CENTER_MAX || rsp_center_x == CENTER_MIN ||
          rsp_center_y == CENTER_MAX || rsp_center_y == CENTER_MIN))
      else $error("saturated flag without a clamped centre");

   // no result shows without an item accepted for it
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (inflight_ff != '0))
      else $error("result presented with nothing in flight");

   // the block never holds more than its stages and queues can store
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= IFW'(CAP))
      else $error("items in flight exceed storage");
`endif

endmodule

// ===== dv/three_point_circumcircle_unit_test.sv =====
`timescale 1ns / 1ps
// three_point_circumcircle_unit_test: self-checking bench for the circumcircle unit
// depends on ccu_pkg and the three_point_circumcircle_unit rtl

module three_point_circumcircle_unit_test import ccu_pkg::*; ();

   localparam int CB = 16;

   // one point triple as seen on the request ports
   typedef struct {
      logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
   } triple_type;

   // circle prediction plus queue of expected circles
   class circle_scoreboard;
      ccu_result_type pending[$];
      int mismatches;
      int checked;

      function longint unsigned floor_root(longint unsigned n);
         longint unsigned root, bit_v;
         root = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > n) bit_v = bit_v >> 2;
         while (bit_v != 0) begin
            if (n >= root + bit_v) begin
               n = n - (root + bit_v);
               root = (root >> 1) + bit_v;
            end else begin
               root = root >> 1;
            end
            bit_v = bit_v >> 2;
         end
         return root;
      endfunction

      function longint clip(longint v, ref bit clipped);
         if (v > longint'(CENTER_MAX)) begin
            clipped = 1;
            return longint'(CENTER_MAX);
         end
         if (v < longint'(CENTER_MIN)) begin
            clipped = 1;
            return longint'(CENTER_MIN);
         end
         return v;
      endfunction

      // note an accepted triple and queue its circle
      function void note_triple(triple_type t);
         longint ux, uy, vx, vy, uu, vv, det, nx, ny, qx, qy, dx, dy;
         bit clipped;
         ccu_result_type r;
         ux = longint'(t.ax) - longint'(t.cx);
         uy = longint'(t.ay) - longint'(t.cy);
         vx = longint'(t.bx) - longint'(t.cx);
         vy = longint'(t.by) - longint'(t.cy);
         uu = ux * ux + uy * uy;
         vv = vx * vx + vy * vy;
         det = 2 * (ux * vy - uy * vx);
         r = '0;
         clipped = 0;
         if (det == 0) begin
            r.degenerate = 1;
         end else begin
            nx = vy * uu - uy * vv;
            ny = ux * vv - vx * uu;
            // sv division truncates toward zero
            qx = (longint'(t.cx) * det + nx) / det;
            qy = (longint'(t.cy) * det + ny) / det;
            qx = clip(qx, clipped);
            qy = clip(qy, clipped);
            dx = qx - longint'(t.cx);
            dy = qy - longint'(t.cy);
            r.center_x = qx[CENTER_W-1:0];
            r.center_y = qy[CENTER_W-1:0];
            r.radius = RADIUS_W'(floor_root(longint'(dx * dx) + longint'(dy * dy)));
            r.saturated = clipped;
         end
         pending.push_back(r);
      endfunction

      // compare one popped circle with the oldest expectation
      function void check_circle(ccu_result_type got);
         ccu_result_type want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got.center_x !== want.center_x || got.center_y !== want.center_y ||
             got.radius !== want.radius || got.degenerate !== want.degenerate ||
             got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_push, req_full, rsp_empty, rsp_pop;
   logic signed [CB-1:0] req_p1_x, req_p1_y, req_p2_x, req_p2_y, req_p3_x, req_p3_y;
   logic signed [CENTER_W-1:0] rsp_center_x, rsp_center_y;
   logic [RADIUS_W-1:0] rsp_radius;
   logic rsp_degenerate, rsp_saturated;

   circle_scoreboard board;
   triple_type stimulus[$];
   bit calm;        // no-idling stretch on both sides
   bit feeding_done;

   three_point_circumcircle_unit #(.COORD_BITS(CB)) DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // generous limit: ~520 items and worst stalls fit many times
   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic triple_type make_triple(int a, b, c, d, e, f);
      triple_type t;
      t.ax = CB'(a); t.ay = CB'(b); t.bx = CB'(c);
      t.by = CB'(d); t.cx = CB'(e); t.cy = CB'(f);
      return t;
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // build directed corners then random triples
   task automatic build_stimulus();
      int mx, mn;
      int kind, s, ox, oy;
      mx = 32767;
      mn = -32768;
      // coincident points
      stimulus.push_back(make_triple(0, 0, 0, 0, 0, 0));
      stimulus.push_back(make_triple(mx, mx, mx, mx, mx, mx));
      // collinear, including a horizontal and a vertical line
      stimulus.push_back(make_triple(1, 2, 3, 4, 5, 6));
      stimulus.push_back(make_triple(mn, 7, 0, 7, mx, 7));
      stimulus.push_back(make_triple(-9, mn, -9, 0, -9, mx));
      stimulus.push_back(make_triple(mn, mn, 0, 0, mx - 1, mx - 1));
      // small right triangle, unit circle and a small isosceles triangle
      stimulus.push_back(make_triple(0, 0, 4, 0, 0, 6));
      stimulus.push_back(make_triple(1, 0, 0, 1, -1, 0));
      stimulus.push_back(make_triple(-3, -3, 3, -3, 0, 2));
      // extremes of the range, largest circles
      stimulus.push_back(make_triple(mn, mn, mx, mn, mn, mx));
      stimulus.push_back(make_triple(mx, mx, mn, mx, mx, mn));
      stimulus.push_back(make_triple(mn, mx, mx, mx, mx, mn));
      stimulus.push_back(make_triple(mn, 0, mx, 0, 0, mx));
      stimulus.push_back(make_triple(mn, mn, mn, mx, mx, 0));
      // nearly collinear: centre far out, saturation
      stimulus.push_back(make_triple(mn, mn, 0, 1, mx, mx));
      stimulus.push_back(make_triple(mn, 0, 0, 1, mx, 0));
      stimulus.push_back(make_triple(mx, 0, 0, -1, mn, 0));
      stimulus.push_back(make_triple(0, mn, 1, 0, 0, mx));
      stimulus.push_back(make_triple(0, mx, -1, 0, 0, mn));
      // negative truncation
      stimulus.push_back(make_triple(-1, 0, 0, -2, -3, -1));
      for (int i = 0; i < 500; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            stimulus.push_back(make_triple(any_coord(), any_coord(), any_coord(),
                                           any_coord(), any_coord(), any_coord()));
         end else if (kind < 7) begin
            // small local triangle
            ox = $urandom_range(0, 60000) - 30000;
            oy = $urandom_range(0, 60000) - 30000;
            stimulus.push_back(make_triple(ox + $urandom_range(0, 40) - 20,
               oy + $urandom_range(0, 40) - 20, ox + $urandom_range(0, 40) - 20,
               oy + $urandom_range(0, 40) - 20, ox + $urandom_range(0, 40) - 20,
               oy + $urandom_range(0, 40) - 20));
         end else if (kind == 7) begin
            // collinear by step
            ox = $urandom_range(0, 200) - 100;
            oy = $urandom_range(0, 200) - 100;
            s = $urandom_range(0, 200) - 100;
            stimulus.push_back(make_triple(s, s, s + ox, s + oy,
                                           s + 2 * ox, s + 2 * oy));
         end else begin
            // near-collinear long chord, often saturating
            ox = $urandom_range(0, 65535) - 32768;
            oy = $urandom_range(0, 65535) - 32768;
            stimulus.push_back(make_triple(ox, oy, ox / 2 + $urandom_range(0, 2) - 1,
               oy / 2 + $urandom_range(0, 2) - 1, 0, 0));
         end
      end
   endtask

   // request side: push one triple per transfer, idling at random
   task automatic feed_triples();
      triple_type t, seen;
      while (stimulus.size() > 0) begin
         @(posedge clock);
         if (req_push && !req_full) begin
            seen.ax = req_p1_x; seen.ay = req_p1_y;
            seen.bx = req_p2_x; seen.by = req_p2_y;
            seen.cx = req_p3_x; seen.cy = req_p3_y;
            board.note_triple(seen);
            void'(stimulus.pop_front());
         end
         if (stimulus.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
            t = stimulus[0];
            req_push <= 1;
            req_p1_x <= t.ax; req_p1_y <= t.ay;
            req_p2_x <= t.bx; req_p2_y <= t.by;
            req_p3_x <= t.cx; req_p3_y <= t.cy;
         end else begin
            req_push <= 0;
         end
      end
      feeding_done = 1;
   endtask

   // result side: sample at the edge, then choose pop for the next cycle
   task automatic drain_circles();
      ccu_result_type got;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            got.center_x = rsp_center_x;
            got.center_y = rsp_center_y;
            got.radius = rsp_radius;
            got.degenerate = rsp_degenerate;
            got.saturated = rsp_saturated;
            board.check_circle(got);
         end
         rsp_pop <= calm || $urandom_range(0, 99) >= 23;
      end
   endtask

   initial begin
      int waited;
      board = new();
      reset = 1;
      req_push = 0;
      rsp_pop = 0;
      calm = 0;
      feeding_done = 0;
      {req_p1_x, req_p1_y, req_p2_x, req_p2_y, req_p3_x, req_p3_y} = '0;
      build_stimulus();
      repeat (11) @(posedge clock);
      reset <= 0;
      fork
         feed_triples();
         drain_circles();
         begin
            // calm stretch in the middle of the run
            repeat (200) @(posedge clock);
            calm = 1;
            repeat (150) @(posedge clock);
            calm = 0;
         end
      join_none
      wait (feeding_done);
      waited = 0;
      while (board.pending.size() > 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      // extra cycles past latency for stray results
      repeat (150) @(posedge clock);
      $display("covered %0d triples: collinear, saturating, extreme and random circles",
               board.checked);
      $display("mismatches %0d, expectations left %0d", board.mismatches,
               board.pending.size());
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
